[rtl/hcv_pkg.sv]
package hcv_pkg;

   // Frame and accumulator geometry
   localparam int MAX_ROWS     = 64;
   localparam int MAX_COLS     = 64;
   localparam int RADIUS_BINS  = 64;
   localparam int ANGLE_STEPS  = 100;
   localparam int RADIUS_STEPS = 100;
   localparam int MAX_PEAKS    = 16;

   localparam int POS_W   = 6;
   localparam int BIN_W   = 6;
   localparam int ADDR_W  = 2 * POS_W + BIN_W;
   localparam int CELLS   = 1 << ADDR_W;
   localparam int DIM_W   = 7;
   localparam int VOTE_W  = 16;
   localparam int THR_W   = 16;
   localparam int ANG_W   = $clog2(ANGLE_STEPS);
   localparam int T_W     = $clog2(RADIUS_STEPS);
   localparam int REM_W   = $clog2(RADIUS_STEPS);
   localparam int NUMR_MAX = (MAX_ROWS < MAX_COLS ? MAX_ROWS : MAX_COLS) / 2 + 1;
   localparam int NUMR_W  = $clog2(NUMR_MAX + 1);
   localparam int FRAC_R  = 16;
   localparam int RQ_W    = BIN_W + FRAC_R;
   localparam int TRIG_W  = 16;
   localparam int PROD_W  = RQ_W + 1 + TRIG_W;
   localparam int FRAC_BITS = 30;
   localparam int D_W     = PROD_W + 1;
   localparam int C_W     = POS_W + 4;
   localparam int SLOT_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int CNT_W   = $clog2(MAX_PEAKS + 1);
   localparam int MIN_BIN = 2;
   localparam int BIN_SEP = 2;
   localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam longint PI_HALF_Q30     = 64'sd1686629713;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032875;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS      = 2'd0,
      CSR_COLS      = 2'd1,
      CSR_THRESHOLD = 2'd2,
      CSR_PEAKS     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VOTE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SEARCH,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [15:0] pixel_value;
      logic        last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]  center_row;
      logic [5:0]  center_col;
      logic [5:0]  radius;
      logic [15:0] votes;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic vote_start;
      logic sweep_read;
      logic sweep_clear;
      logic sweep_next;
      logic pos_advance;
      logic pos_reset;
   } accum_cmd_type;

   typedef struct packed {
      logic vote_busy;
      logic sweep_last;
      logic cell_hit;
   } accum_status_type;

   typedef struct packed {
      logic search_start;
      logic search_step;
      logic update;
      logic emit_start;
      logic emit_load;
      logic slots_clear;
   } peak_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic emit_last;
      logic rsp_free;
   } peak_status_type;

   typedef struct packed {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [BIN_W-1:0]  bin;
      logic [VOTE_W-1:0] votes;
   } cell_type;

   typedef logic signed [TRIG_W-1:0] trig_table_type [ANGLE_STEPS];
   typedef logic [RQ_W-1:0]  step_q_table_type [NUMR_MAX + 1];
   typedef logic [REM_W-1:0] step_r_table_type [NUMR_MAX + 1];

   function automatic longint shr_trunc(input longint v, input int s);
      return (v >= 0) ? (v >>> s) : -((-v) >>> s);
   endfunction

   function automatic longint atan_q30(input int i);
      longint r;
      case (i)
         0:       r = 64'sd843314857;
         1:       r = 64'sd497837830;
         2:       r = 64'sd263043837;
         3:       r = 64'sd133525160;
         4:       r = 64'sd67021712;
         5:       r = 64'sd33543516;
         6:       r = 64'sd16775851;
         7:       r = 64'sd8388437;
         8:       r = 64'sd4194283;
         9:       r = 64'sd2097149;
         default: r = 64'sd1 <<< (30 - i);
      endcase
      return r;
   endfunction

   function automatic longint q30_to_q14(input longint v);
      longint w;
      w = (v < 0) ? 64'sd0 : v;
      return (w + 64'sd32768) >>> 16;
   endfunction

   // Integer CORDIC over the angle within its quadrant, then quadrant symmetry.
   function automatic trig_table_type build_trig(input bit want_sin);
      trig_table_type tbl;
      longint x, y, z, dx, dy, c, s, r;
      int quad, rem;
      for (int a = 0; a < ANGLE_STEPS; a++) begin
         quad = (4 * a) / ANGLE_STEPS;
         rem  = 4 * a - quad * ANGLE_STEPS;
         z = PI_HALF_Q30 * longint'(rem) / ANGLE_STEPS;
         x = CORDIC_GAIN_Q30;
         y = 0;
         for (int i = 0; i < 30; i++) begin
            dx = shr_trunc(y, i);
            dy = shr_trunc(x, i);
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - atan_q30(i);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + atan_q30(i);
            end
         end
         c = q30_to_q14(x);
         s = q30_to_q14(y);
         case (quad & 3)
            0:       r = want_sin ? s : c;
            1:       r = want_sin ? c : -s;
            2:       r = want_sin ? -s : -c;
            default: r = want_sin ? -c : s;
         endcase
         tbl[a] = TRIG_W'(r);
      end
      return tbl;
   endfunction

   // Radius increment per sample, split into whole steps and a remainder.
   function automatic step_q_table_type build_step_q();
      step_q_table_type tbl;
      for (int n = 0; n <= NUMR_MAX; n++) begin
         tbl[n] = RQ_W'((longint'(n) <<< FRAC_R) / RADIUS_STEPS);
      end
      return tbl;
   endfunction

   function automatic step_r_table_type build_step_r();
      step_r_table_type tbl;
      for (int n = 0; n <= NUMR_MAX; n++) begin
         tbl[n] = REM_W'((longint'(n) <<< FRAC_R) % RADIUS_STEPS);
      end
      return tbl;
   endfunction

   localparam trig_table_type   COS_TABLE    = build_trig(1'b0);
   localparam trig_table_type   SIN_TABLE    = build_trig(1'b1);
   localparam step_q_table_type STEP_Q_TABLE = build_step_q();
   localparam step_r_table_type STEP_R_TABLE = build_step_r();

endpackage

[rtl/hough_circle_vote_topk.sv]
// Circle finder by Hough voting over an edge map fed in raster order, one pixel
// per transfer. A pixel below the threshold is taken without voting. A pixel at
// or above it forms 9900 candidate votes (100 angles by 99 radius samples) for a
// read-modify-write pipeline on the vote memory, one vote a cycle; votes whose
// centre falls outside the frame are dropped. On the pixel marked last the
// whole 262144-cell vote memory is swept, and each non-zero cell inside the
// frame in radius bin 2 or above goes through a peak list update; the sweep
// also zeroes the memory. Results then leave one per cycle through an output
// register while rsp_ready is held. After reset a clearing pass over every
// cell runs before the first pixel is accepted; configuration writes are
// taken at once.
module hough_circle_vote_topk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  hcv_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output hcv_pkg::rsp_payload_type       rsp_payload,
   input  logic                           csr_we,
   input  logic [hcv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hcv_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hcv_pkg::*;

   logic [DIM_W-1:0] image_rows_ff, image_cols_ff;
   logic [THR_W-1:0] edge_threshold_ff;
   logic [CNT_W-1:0] peak_count_ff;
   logic [DIM_W-1:0] rows, cols;
   logic [CNT_W-1:0] peak_k;
   logic             pix_votes;

   accum_cmd_type    acc_cmd;
   accum_status_type acc_status;
   peak_cmd_type     pk_cmd;
   peak_status_type  pk_status;
   cell_type         scan_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_rows_ff     <= DIM_W'(64);
         image_cols_ff     <= DIM_W'(64);
         edge_threshold_ff <= THR_W'(10);
         peak_count_ff     <= CNT_W'(16);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS:      image_rows_ff     <= csr_wdata[DIM_W-1:0];
            CSR_COLS:      image_cols_ff     <= csr_wdata[DIM_W-1:0];
            CSR_THRESHOLD: edge_threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_PEAKS:     peak_count_ff     <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range register values are used clamped to the supported range.
   always_comb begin
      rows = (image_rows_ff == '0) ? DIM_W'(1)
           : (image_rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : image_rows_ff;
      cols = (image_cols_ff == '0) ? DIM_W'(1)
           : (image_cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : image_cols_ff;
      peak_k = (peak_count_ff == '0) ? CNT_W'(1)
             : (peak_count_ff > CNT_W'(MAX_PEAKS)) ? CNT_W'(MAX_PEAKS) : peak_count_ff;
      pix_votes = (req_payload.pixel_value >= edge_threshold_ff);
   end

   hcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_last   (req_payload.last_pixel),
      .pix_votes  (pix_votes),
      .req_ready  (req_ready),
      .acc_status (acc_status),
      .acc_cmd    (acc_cmd),
      .pk_status  (pk_status),
      .pk_cmd     (pk_cmd)
   );

   hcv_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cmd       (acc_cmd),
      .rows      (rows),
      .cols      (cols),
      .status    (acc_status),
      .scan_cell (scan_cell)
   );

   hcv_peaks u_peaks (
      .clock       (clock),
      .reset       (reset),
      .cmd         (pk_cmd),
      .scan_cell   (scan_cell),
      .peak_k      (peak_k),
      .status      (pk_status),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/hcv_accum.sv]
module hcv_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  hcv_pkg::accum_cmd_type    cmd,
   input  logic [hcv_pkg::DIM_W-1:0] rows,
   input  logic [hcv_pkg::DIM_W-1:0] cols,
   output hcv_pkg::accum_status_type status,
   output hcv_pkg::cell_type         scan_cell
);
   import hcv_pkg::*;

   function automatic logic signed [C_W-1:0] centre_coord(
      input logic [POS_W-1:0] p,
      input logic signed [PROD_W-1:0] prod);
      logic [D_W-1:0] d;
      logic [D_W-1:0] mag;
      logic [D_W-1:0] q;
      logic [D_W-1:0] r;
      d = {{(D_W-POS_W-FRAC_BITS){1'b0}}, p, {FRAC_BITS{1'b0}}}
          - {{(D_W-PROD_W){prod[PROD_W-1]}}, prod};
      mag = d[D_W-1] ? (~d + 1'b1) : d;
      q = mag >> FRAC_BITS;
      r = d[D_W-1] ? (~q + 1'b1) : q;
      return r[C_W-1:0];
   endfunction

   // Sweep counter and pixel position
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [POS_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [POS_W:0]    col_inc, row_inc;

   // Vote generator
   logic              gen_active_ff, gen_active_in;
   logic [ANG_W-1:0]  ang_ff, ang_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [RQ_W-1:0]   rq_ff, rq_in, stepq_ff, stepq_in;
   logic [REM_W-1:0]  rrem_ff, rrem_in, stepr_ff, stepr_in;
   logic [REM_W:0]    rsum;
   logic [DIM_W-1:0]  min_dim;
   logic [NUMR_W-1:0] numr;

   // Address pipeline
   logic                     v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [TRIG_W-1:0] cos1_ff, sin1_ff;
   logic [RQ_W-1:0]          rq1_ff;
   logic signed [PROD_W-1:0] prodx2_ff, prody2_ff;
   logic [BIN_W-1:0]         bin2_ff;
   logic signed [C_W-1:0]    xc, yc;
   logic                     in_frame;
   logic [ADDR_W-1:0]        addr3_ff, addr4_ff;

   // Memory and read-modify-write
   logic [VOTE_W-1:0] mem [CELLS];
   logic [VOTE_W-1:0] mem_q_ff;
   logic [ADDR_W-1:0] raddr, waddr;
   logic [VOTE_W-1:0] wdata, cur, inc;
   logic              we;
   logic              fwd_v_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [VOTE_W-1:0] fwd_data_ff;

   always_comb begin
      sweep_in = cmd.sweep_next ? sweep_ff + 1'b1 : sweep_ff;
   end

   always_comb begin
      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.pos_reset) begin
         row_in = '0;
         col_in = '0;
      end else if (cmd.pos_advance) begin
         if (DIM_W'(col_inc) >= cols) begin
            col_in = '0;
            row_in = (DIM_W'(row_inc) >= rows) ? '0 : row_inc[POS_W-1:0];
         end else begin
            col_in = col_inc[POS_W-1:0];
         end
      end
   end

   always_comb begin
      min_dim = (rows < cols) ? rows : cols;
      numr    = NUMR_W'(min_dim >> 1) + NUMR_W'(1);
      rsum    = {1'b0, rrem_ff} + {1'b0, stepr_ff};
      gen_active_in = gen_active_ff;
      ang_in   = ang_ff;
      t_in     = t_ff;
      rq_in    = rq_ff;
      rrem_in  = rrem_ff;
      stepq_in = stepq_ff;
      stepr_in = stepr_ff;
      if (cmd.vote_start) begin
         gen_active_in = 1'b1;
         ang_in   = '0;
         t_in     = T_W'(1);
         stepq_in = STEP_Q_TABLE[numr];
         stepr_in = STEP_R_TABLE[numr];
         rq_in    = STEP_Q_TABLE[numr];
         rrem_in  = STEP_R_TABLE[numr];
      end else if (gen_active_ff) begin
         if (t_ff == T_W'(RADIUS_STEPS - 1)) begin
            t_in    = T_W'(1);
            rq_in   = stepq_ff;
            rrem_in = stepr_ff;
            if (ang_ff == ANG_W'(ANGLE_STEPS - 1)) begin
               gen_active_in = 1'b0;
            end else begin
               ang_in = ang_ff + 1'b1;
            end
         end else begin
            t_in = t_ff + 1'b1;
            if (rsum >= (REM_W+1)'(RADIUS_STEPS)) begin
               rrem_in = REM_W'(rsum - (REM_W+1)'(RADIUS_STEPS));
               rq_in   = rq_ff + stepq_ff + 1'b1;
            end else begin
               rrem_in = rsum[REM_W-1:0];
               rq_in   = rq_ff + stepq_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         gen_active_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         fwd_v_ff      <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         gen_active_ff <= gen_active_in;
         v1_ff         <= gen_active_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff && in_frame;
         v4_ff         <= v3_ff;
         fwd_v_ff      <= v4_ff;
      end
   end

   always_comb begin
      xc = centre_coord(row_ff, prodx2_ff);
      yc = centre_coord(col_ff, prody2_ff);
      in_frame = !xc[C_W-1] && (xc[C_W-2:0] < (C_W-1)'(rows))
              && !yc[C_W-1] && (yc[C_W-2:0] < (C_W-1)'(cols));
   end

   always_ff @(posedge clock) begin
      ang_ff    <= ang_in;
      t_ff      <= t_in;
      rq_ff     <= rq_in;
      rrem_ff   <= rrem_in;
      stepq_ff  <= stepq_in;
      stepr_ff  <= stepr_in;
      cos1_ff   <= COS_TABLE[ang_ff];
      sin1_ff   <= SIN_TABLE[ang_ff];
      rq1_ff    <= rq_ff;
      prodx2_ff <= $signed({1'b0, rq1_ff}) * cos1_ff;
      prody2_ff <= $signed({1'b0, rq1_ff}) * sin1_ff;
      bin2_ff   <= rq1_ff[RQ_W-1:FRAC_R];
      addr3_ff  <= {xc[POS_W-1:0], yc[POS_W-1:0], bin2_ff};
      addr4_ff  <= addr3_ff;
      fwd_addr_ff <= addr4_ff;
      fwd_data_ff <= inc;
   end

   // The write of the vote just ahead lands on the same edge as this read,
   // so its value is taken from the forwarding register instead.
   always_comb begin
      cur = (fwd_v_ff && (fwd_addr_ff == addr4_ff)) ? fwd_data_ff : mem_q_ff;
      inc = (cur == VOTE_MAX) ? cur : cur + 1'b1;
      raddr = cmd.sweep_read ? sweep_ff : addr3_ff;
      we    = v4_ff || cmd.sweep_read || cmd.sweep_clear;
      waddr = v4_ff ? addr4_ff : sweep_ff;
      wdata = v4_ff ? inc : '0;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[raddr];
   end

   always_comb begin
      scan_cell.row   = sweep_ff[ADDR_W-1 -: POS_W];
      scan_cell.col   = sweep_ff[BIN_W +: POS_W];
      scan_cell.bin   = sweep_ff[BIN_W-1:0];
      scan_cell.votes = mem_q_ff;
      status.vote_busy  = gen_active_ff || v1_ff || v2_ff || v3_ff || v4_ff;
      status.sweep_last = &sweep_ff;
      status.cell_hit   = (mem_q_ff != '0)
                        && ({1'b0, scan_cell.row} < rows)
                        && ({1'b0, scan_cell.col} < cols)
                        && (scan_cell.bin >= BIN_W'(MIN_BIN));
   end

endmodule

[rtl/hcv_peaks.sv]
module hcv_peaks (
   input  logic                      clock,
   input  logic                      reset,
   input  hcv_pkg::peak_cmd_type     cmd,
   input  hcv_pkg::cell_type         scan_cell,
   input  logic [hcv_pkg::CNT_W-1:0] peak_k,
   output hcv_pkg::peak_status_type  status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output hcv_pkg::rsp_payload_type  rsp_payload
);
   import hcv_pkg::*;

   logic [SLOT_W-1:0] idx_ff, idx_in, m_ff, m_in;
   logic              min_used_ff, min_used_in;
   logic [VOTE_W-1:0] min_votes_ff, min_votes_in;
   logic [BIN_W-1:0]  mprev_ff, mprev_in, last_rad_ff, last_rad_in;
   cell_type          cell_ff;

   logic [MAX_PEAKS-1:0] used_ff;
   logic [VOTE_W-1:0]    slot_votes_ff  [MAX_PEAKS];
   logic [POS_W-1:0]     slot_row_ff    [MAX_PEAKS];
   logic [POS_W-1:0]     slot_col_ff    [MAX_PEAKS];
   logic [BIN_W-1:0]     slot_radius_ff [MAX_PEAKS];
   logic [CNT_W-1:0]     filled_ff;

   logic              rd_used;
   logic [VOTE_W-1:0] rd_votes;
   logic [BIN_W-1:0]  rd_radius, diff;
   logic              distinct, take;
   logic [CNT_W-1:0]  idx_next;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   always_comb begin
      rd_used   = used_ff[idx_ff];
      rd_votes  = slot_votes_ff[idx_ff];
      rd_radius = slot_radius_ff[idx_ff];
      idx_next  = CNT_W'(idx_ff) + CNT_W'(1);
      status.idx_last  = (idx_next == peak_k);
      status.emit_last = (filled_ff == '0) || (idx_next == filled_ff);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // One slot is examined per cycle; the first slot with the lowest count wins,
   // an empty slot counting as lower than any used one.
   always_comb begin
      idx_in       = idx_ff;
      m_in         = m_ff;
      min_used_in  = min_used_ff;
      min_votes_in = min_votes_ff;
      mprev_in     = mprev_ff;
      last_rad_in  = last_rad_ff;
      if (cmd.search_start || cmd.emit_start) begin
         idx_in = '0;
      end else if (cmd.search_step) begin
         idx_in      = idx_ff + 1'b1;
         last_rad_in = rd_radius;
         if (idx_ff == '0) begin
            m_in         = '0;
            min_used_in  = rd_used;
            min_votes_in = rd_votes;
         end else if (min_used_ff && (!rd_used || (rd_votes < min_votes_ff))) begin
            m_in         = idx_ff;
            min_used_in  = rd_used;
            min_votes_in = rd_votes;
            mprev_in     = last_rad_ff;
         end
      end else if (cmd.emit_load) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      diff     = (mprev_ff > cell_ff.bin) ? mprev_ff - cell_ff.bin : cell_ff.bin - mprev_ff;
      distinct = (m_ff == '0) || (diff > BIN_W'(BIN_SEP));
      take     = cmd.update && (!min_used_ff || (cell_ff.votes > min_votes_ff)) && distinct;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         if (filled_ff == '0) begin
            rsp_payload_in      = '0;
            rsp_payload_in.last = 1'b1;
         end else begin
            rsp_payload_in.center_row = slot_row_ff[idx_ff];
            rsp_payload_in.center_col = slot_col_ff[idx_ff];
            rsp_payload_in.radius     = slot_radius_ff[idx_ff];
            rsp_payload_in.votes      = slot_votes_ff[idx_ff];
            rsp_payload_in.last       = status.emit_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         filled_ff    <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.slots_clear) begin
            used_ff   <= '0;
            filled_ff <= '0;
         end else if (take) begin
            used_ff[m_ff] <= 1'b1;
            if (!min_used_ff) begin
               filled_ff <= filled_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff           <= m_in;
      min_used_ff    <= min_used_in;
      min_votes_ff   <= min_votes_in;
      mprev_ff       <= mprev_in;
      last_rad_ff    <= last_rad_in;
      rsp_payload_ff <= rsp_payload_in;
      if (cmd.search_start) begin
         cell_ff <= scan_cell;
      end
      if (take) begin
         slot_votes_ff[m_ff]  <= cell_ff.votes;
         slot_row_ff[m_ff]    <= cell_ff.row;
         slot_col_ff[m_ff]    <= cell_ff.col;
         slot_radius_ff[m_ff] <= cell_ff.bin;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[rtl/hcv_ctrl.sv]
module hcv_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_last,
   input  logic                      pix_votes,
   output logic                      req_ready,
   input  hcv_pkg::accum_status_type acc_status,
   output hcv_pkg::accum_cmd_type    acc_cmd,
   input  hcv_pkg::peak_status_type  pk_status,
   output hcv_pkg::peak_cmd_type     pk_cmd
);
   import hcv_pkg::*;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      last_in = accept ? req_last : last_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (acc_status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (pix_votes)     state_in = ST_VOTE;
               else if (req_last) state_in = ST_SCAN_RD;
            end
         end
         ST_VOTE: begin
            if (!acc_status.vote_busy) state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (acc_status.cell_hit)        state_in = ST_SEARCH;
            else if (acc_status.sweep_last) state_in = ST_EMIT;
            else                            state_in = ST_SCAN_RD;
         end
         ST_SEARCH: begin
            if (pk_status.idx_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = acc_status.sweep_last ? ST_EMIT : ST_SCAN_RD;
         ST_EMIT: begin
            if (pk_status.rsp_free && pk_status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      acc_cmd   = '0;
      pk_cmd    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            acc_cmd.sweep_clear = 1'b1;
            acc_cmd.sweep_next  = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (pix_votes)     acc_cmd.vote_start  = 1'b1;
               else if (req_last) acc_cmd.pos_reset   = 1'b1;
               else               acc_cmd.pos_advance = 1'b1;
            end
         end
         ST_VOTE: begin
            if (!acc_status.vote_busy) begin
               if (last_ff) acc_cmd.pos_reset   = 1'b1;
               else         acc_cmd.pos_advance = 1'b1;
            end
         end
         ST_SCAN_RD: acc_cmd.sweep_read = 1'b1;
         ST_SCAN_CHK: begin
            if (acc_status.cell_hit) begin
               pk_cmd.search_start = 1'b1;
            end else begin
               acc_cmd.sweep_next = 1'b1;
               pk_cmd.emit_start  = acc_status.sweep_last;
            end
         end
         ST_SEARCH: pk_cmd.search_step = 1'b1;
         ST_UPDATE: begin
            pk_cmd.update      = 1'b1;
            acc_cmd.sweep_next = 1'b1;
            pk_cmd.emit_start  = acc_status.sweep_last;
         end
         ST_EMIT: begin
            if (pk_status.rsp_free) begin
               pk_cmd.emit_load   = 1'b1;
               pk_cmd.slots_clear = pk_status.emit_last;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule
